// ===== src/lcfs_pkg.sv =====
// Package for the LED chain frame serializer.
// Holds the byte constants, the command struct passed from front to back and
// the queue depth. No dependencies.
package lcfs_pkg;

    localparam logic [7:0] HDR_BASE   = 8'hC0;
    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'hFF;

    // Byte slot numbers inside one command: start 0..3, LED 4..7, end 8..11
    localparam logic [3:0] SLOT_FIRST_START = 4'd0;
    localparam logic [3:0] SLOT_LAST_START  = 4'd3;
    localparam logic [3:0] SLOT_HDR         = 4'd4;
    localparam logic [3:0] SLOT_BLUE        = 4'd5;
    localparam logic [3:0] SLOT_GREEN       = 4'd6;
    localparam logic [3:0] SLOT_RED         = 4'd7;
    localparam logic [3:0] SLOT_FIRST_END   = 4'd8;
    localparam logic [3:0] SLOT_LAST_END    = 4'd11;

    localparam int QUEUE_DEPTH = 2;

    // One classified LED, ready to be expanded into bytes
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       with_start;
        logic       with_end;
    } cmd_t;

endpackage

// ===== src/lcfs_front.sv =====
// Front end: takes LED transfers, tracks frame and blink phase, builds commands.
// Depends on lcfs_pkg.
module lcfs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_fire,
    input  logic [5:0]        brightness,
    input  logic [7:0]        blue,
    input  logic [7:0]        green,
    input  logic [7:0]        red,
    input  logic              last_led,
    output lcfs_pkg::cmd_t    cmd
);

    logic blink_mode_reg;
    logic in_frame_reg,    in_frame_next;
    logic blink_phase_reg, blink_phase_next;
    logic phase_eff;
    logic blank;

    always_comb
    begin
        // phase flips when a frame opens in blink mode
        phase_eff = in_frame_reg ? blink_phase_reg : (blink_phase_reg ^ blink_mode_reg);
        blank     = blink_mode_reg && !phase_eff;

        cmd.hdr        = lcfs_pkg::HDR_BASE | {2'b00, blank ? 6'd0 : brightness};
        cmd.blue       = blue;
        cmd.green      = green;
        cmd.red        = red;
        cmd.with_start = !in_frame_reg;
        cmd.with_end   = last_led;

        in_frame_next    = in_frame_reg;
        blink_phase_next = blink_phase_reg;
        if (in_fire)
        begin
            in_frame_next    = !last_led;
            blink_phase_next = phase_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_mode_reg  <= 1'b0;
            in_frame_reg    <= 1'b0;
            blink_phase_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                blink_mode_reg <= cfg_wdata;
            end
            in_frame_reg    <= in_frame_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

endmodule

// ===== src/lcfs_queue.sv =====
// Small command queue between front and back, built from flops.
// Depends on lcfs_pkg.
module lcfs_queue
#(
    parameter int DEPTH = lcfs_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcfs_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output lcfs_pkg::cmd_t pop_data,
    output logic           empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcfs_pkg::cmd_t  mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/lcfs_back.sv =====
// Back end: expands each command into its LED bytes, with start and end bytes when
// flagged, one per cycle while m_tready allows, into a registered output stage. Depends on lcfs_pkg.
module lcfs_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lcfs_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);

    logic           busy_reg, busy_next;
    lcfs_pkg::cmd_t cmd_reg,  cmd_next;
    logic [3:0]     slot_reg, slot_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_byte_reg,  out_byte_next;
    logic           out_last_reg,  out_last_next;
    logic           out_done_reg,  out_done_next;
    logic           advance;
    logic           final_slot;
    logic [7:0]     slot_byte;

    assign advance    = !out_valid_reg || m_tready;
    assign final_slot = (slot_reg == lcfs_pkg::SLOT_LAST_END) ||
                        ((slot_reg == lcfs_pkg::SLOT_RED) && !cmd_reg.with_end);
    assign q_pop      = advance && (!busy_reg || final_slot) && !q_empty;

    always_comb
    begin
        case (slot_reg) inside
            [lcfs_pkg::SLOT_FIRST_START:lcfs_pkg::SLOT_LAST_START]: slot_byte = lcfs_pkg::START_BYTE;
            lcfs_pkg::SLOT_HDR:   slot_byte = cmd_reg.hdr;
            lcfs_pkg::SLOT_BLUE:  slot_byte = cmd_reg.blue;
            lcfs_pkg::SLOT_GREEN: slot_byte = cmd_reg.green;
            lcfs_pkg::SLOT_RED:   slot_byte = cmd_reg.red;
            default:              slot_byte = lcfs_pkg::END_BYTE;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            out_byte_next  = slot_byte;
            out_last_next  = final_slot;
            out_done_next  = (slot_reg == lcfs_pkg::SLOT_LAST_END);
            if (busy_reg)
            begin
                slot_next = slot_reg + 4'd1;
                if (final_slot)
                begin
                    busy_next = 1'b0;
                end
            end
            // next command loads as the current one sends its final byte
            if (q_pop)
            begin
                busy_next = 1'b1;
                cmd_next  = q_data;
                slot_next = q_data.with_start ? lcfs_pkg::SLOT_FIRST_START : lcfs_pkg::SLOT_HDR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= lcfs_pkg::SLOT_FIRST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("frame_done without last_of_run");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> slot_reg <= lcfs_pkg::SLOT_LAST_END)
        else $error("byte slot out of range");

    a_led_slot_end: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !cmd_reg.with_end |-> slot_reg <= lcfs_pkg::SLOT_RED)
        else $error("end bytes on a command without end");

    a_pop_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg || final_slot)
        else $error("command loaded while back end busy");

endmodule

// ===== src/led_chain_frame_serializer.sv =====
// LED chain frame serializer, top level.
// An item's first byte passes the queue, the back end's command register and the
// output byte register before it shows on m_tvalid. Throughput: one byte per cycle
// while m_tready allows; 4 bytes per LED, 4 start and 4 end bytes per frame.
// Reset: asynchronous, clears frame state, blink phase, blink_mode and the queue.
// Depends on lcfs_pkg, lcfs_front, lcfs_queue, lcfs_back.
module led_chain_frame_serializer
#(
    parameter int QUEUE_DEPTH = lcfs_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // blink_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // brightness[5:0], blue, green, red, 2 zero bits
    input  logic        s_tlast,       // last_led
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // out_byte
    output logic        m_tlast,       // last_of_run
    output logic        m_tuser        // frame_done
);

    lcfs_pkg::cmd_t front_cmd;
    lcfs_pkg::cmd_t q_data;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           in_fire;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    lcfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_fire    (in_fire),
        .brightness (s_tdata[5:0]),
        .blue       (s_tdata[13:6]),
        .green      (s_tdata[21:14]),
        .red        (s_tdata[29:22]),
        .last_led   (s_tlast),
        .cmd        (front_cmd)
    );

    lcfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    lcfs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
